FILE: hdl/lpc_pkg.sv
// shared types, widths and constants of the lidar point covariance block
// used by lpc_sin_seq, lpc_div_pipe and lidar_point_covariance_top
package lpc_pkg;

   localparam int COORD_W = 32;
   localparam int COV_W   = 48;
   localparam int PM_W    = 63;   // |p_i p_j|
   localparam int R_W     = 64;   // |p|^2
   localparam int S2_W    = 34;   // range_std^2
   localparam int SN2_W   = 33;   // sin^2 in q1.32
   localparam int T2_W    = 51;   // clamped angle term
   localparam int QUO_W   = 35;   // range term quotient
   localparam int NUM_W   = 97;   // range term dividend
   localparam int LANES   = 6;
   localparam int RSTD_W  = 17;
   localparam int ANG_W   = 16;

   localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
   localparam logic [63:0] RAD_PER_MDEG = PI_Q60 / 64'd180000;
   localparam logic [T2_W-1:0] MAG_CLAMP = T2_W'(1) << 50;

   // 2^64, numerator of the taylor divisor reciprocals
   localparam logic [64:0] TWO_64 = 65'd1 << 64;

   // register indexes
   localparam logic [0:0] CSR_RANGE_STD = 1'b0;
   localparam logic [0:0] CSR_ANGLE_STD = 1'b1;

   localparam logic [RSTD_W-1:0] RANGE_STD_RESET = 17'd1311;
   localparam logic [ANG_W-1:0]  ANGLE_STD_RESET = 16'd100;

   // lane order: xx xy xz yy yz zz
   localparam logic [1:0] ROW_SEL [LANES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] COL_SEL [LANES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
   localparam logic [LANES-1:0] DIAG_LANES = 6'b101001;

   typedef struct packed {
      logic [COORD_W-1:0]           z;
      logic [LANES-1:0]             negp;
      logic [LANES-1:0][T2_W-1:0]   t2;
   } side_type;

   // divisor (2k)(2k+1) of the k-th taylor term
   function automatic logic [8:0] term_divisor(input logic [3:0] k);
      logic [8:0] d;
      unique case (k)
         4'd1:    d = 9'd6;
         4'd2:    d = 9'd20;
         4'd3:    d = 9'd42;
         4'd4:    d = 9'd72;
         4'd5:    d = 9'd110;
         4'd6:    d = 9'd156;
         4'd7:    d = 9'd210;
         4'd8:    d = 9'd272;
         4'd9:    d = 9'd342;
         4'd10:   d = 9'd420;
         default: d = 9'd6;
      endcase
      return d;
   endfunction

   // floor(2^64 / divisor) of the k-th taylor term
   function automatic logic [63:0] term_recip(input logic [3:0] k);
      logic [63:0] m;
      unique case (k)
         4'd1:    m = 64'(TWO_64 / 65'd6);
         4'd2:    m = 64'(TWO_64 / 65'd20);
         4'd3:    m = 64'(TWO_64 / 65'd42);
         4'd4:    m = 64'(TWO_64 / 65'd72);
         4'd5:    m = 64'(TWO_64 / 65'd110);
         4'd6:    m = 64'(TWO_64 / 65'd156);
         4'd7:    m = 64'(TWO_64 / 65'd210);
         4'd8:    m = 64'(TWO_64 / 65'd272);
         4'd9:    m = 64'(TWO_64 / 65'd342);
         4'd10:   m = 64'(TWO_64 / 65'd420);
         default: m = 64'(TWO_64 / 65'd6);
      endcase
      return m;
   endfunction

endpackage

FILE: hdl/lidar_point_covariance_top.sv
// Lidar point covariance: one point (x, y, z) per cycle in while req_tready is high, one
// six-entry covariance item out, fully pipelined. The path runs through seven input and
// arithmetic stages, the 35-stage range term divider (one quotient bit per stage), and the
// output register. After reset and after each write of the angle register the sine squared
// unit runs ten taylor terms, each built from 32x32 partial products and a reciprocal
// multiply with one correction step, and req_tready is low during that time.
// depends on lpc_pkg, lpc_sin_seq, lpc_div_pipe
module lidar_point_covariance_top #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [95:0]   req_tdata,   // point_x, point_y, point_z
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [319:0]  rsp_tdata,   // cov_xx, cov_xy, cov_xz, cov_yy, cov_yz, cov_zz, adjusted_z
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [0:0]    csr_index,
   input  logic [16:0]   csr_data
);

   localparam int CW  = lpc_pkg::COORD_W;
   localparam int NL  = lpc_pkg::LANES;
   localparam int QW  = lpc_pkg::QUO_W;
   localparam int EPS_RAW = ((1 << COORD_FRAC_BITS) + 500) / 1000;
   localparam logic [CW-1:0] EPS = (EPS_RAW == 0) ? CW'(1) : CW'(EPS_RAW);
   localparam logic [97:0] ROUND = 98'd1 << (2 * COORD_FRAC_BITS - 1);

   // configuration
   logic [lpc_pkg::RSTD_W-1:0] rstd_ff;
   logic [lpc_pkg::ANG_W-1:0]  ang_ff;
   logic [lpc_pkg::S2_W-1:0]   s2_ff;
   logic [lpc_pkg::SN2_W-1:0]  sn2;
   logic                       busy, ang_wr;

   assign csr_ready = 1'b1;
   assign ang_wr    = csr_valid && (csr_index == lpc_pkg::CSR_ANGLE_STD);

   always_ff @(posedge clock) begin
      if (reset) begin
         rstd_ff <= lpc_pkg::RANGE_STD_RESET;
         ang_ff  <= lpc_pkg::ANGLE_STD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            lpc_pkg::CSR_RANGE_STD: rstd_ff <= csr_data;
            lpc_pkg::CSR_ANGLE_STD: ang_ff  <= csr_data[lpc_pkg::ANG_W-1:0];
            default: ;
         endcase
      end
      s2_ff <= rstd_ff * rstd_ff;
   end

   lpc_sin_seq u_sin (
      .clock (clock),
      .reset (reset),
      .start (ang_wr),
      .mdeg  (ang_ff),
      .busy  (busy),
      .sn2   (sn2)
   );

   // flow control
   logic out_v_ff, last_v, en, out_ld;
   assign out_ld     = !out_v_ff || rsp_tready;
   assign en         = out_ld || !last_v;
   assign req_tready = en && !busy;

   // stage 0: input
   logic                 v0_ff;
   logic signed [CW-1:0] p0_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid && !busy;
      end
      if (en) begin
         p0_ff[0] <= req_tdata[31:0];
         p0_ff[1] <= req_tdata[63:32];
         p0_ff[2] <= req_tdata[95:64];
      end
   end

   // stage 1: zero z, magnitudes
   logic          v1_ff;
   logic [CW-1:0] mag1_ff [3];
   logic [2:0]    neg1_ff;
   logic [CW-1:0] z1_ff;
   logic [CW-1:0] p1_in [3];
   always_comb begin
      p1_in[0] = p0_ff[0];
      p1_in[1] = p0_ff[1];
      p1_in[2] = (p0_ff[2] == '0) ? EPS : p0_ff[2];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= p1_in[i][CW-1];
            mag1_ff[i] <= p1_in[i][CW-1] ? CW'(-p1_in[i]) : p1_in[i];
         end
         z1_ff <= p1_in[2];
      end
   end

   // stage 2: products
   logic                  v2_ff;
   logic [lpc_pkg::PM_W-1:0] pm2_ff [NL];
   logic [2:0]            neg2_ff;
   logic [CW-1:0]         z2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         for (int k = 0; k < NL; k++) begin
            pm2_ff[k] <= lpc_pkg::PM_W'(mag1_ff[lpc_pkg::ROW_SEL[k]] *
                                         mag1_ff[lpc_pkg::COL_SEL[k]]);
         end
         neg2_ff <= neg1_ff;
         z2_ff   <= z1_ff;
      end
   end

   // stage 3: squared range, range term partial products
   logic                     v3_ff;
   logic [lpc_pkg::R_W-1:0]  r3_ff;
   logic [lpc_pkg::PM_W-1:0] pm3_ff [NL];
   logic [64:0]              plo3_ff [NL];
   logic [65:0]              phi3_ff [NL];
   logic [NL-1:0]            negp3_ff;
   logic [CW-1:0]            z3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         r3_ff <= 64'(pm2_ff[0]) + 64'(pm2_ff[3]) + 64'(pm2_ff[5]);
         for (int k = 0; k < NL; k++) begin
            pm3_ff[k]   <= pm2_ff[k];
            plo3_ff[k]  <= s2_ff * pm2_ff[k][30:0];
            phi3_ff[k]  <= s2_ff * pm2_ff[k][62:31];
            negp3_ff[k] <= (neg2_ff[lpc_pkg::ROW_SEL[k]] != neg2_ff[lpc_pkg::COL_SEL[k]])
                           && (pm2_ff[k] != '0);
         end
         z3_ff <= z2_ff;
      end
   end

   // stage 4: dividend and angle operand
   logic                      v4_ff;
   logic [lpc_pkg::R_W-1:0]   r4_ff;
   logic [lpc_pkg::NUM_W-1:0] num4_ff [NL];
   logic [63:0]               u4_ff [NL];
   logic [NL-1:0]             negp4_ff;
   logic [CW-1:0]             z4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         r4_ff <= r3_ff;
         for (int k = 0; k < NL; k++) begin
            num4_ff[k] <= 97'(plo3_ff[k]) + (97'(phi3_ff[k]) << 31) + 97'(r3_ff >> 1);
            u4_ff[k]   <= lpc_pkg::DIAG_LANES[k] ? r3_ff - 64'(pm3_ff[k]) : 64'(pm3_ff[k]);
         end
         negp4_ff <= negp3_ff;
         z4_ff    <= z3_ff;
      end
   end

   // stage 5: angle term partial products
   logic                      v5_ff;
   logic [lpc_pkg::R_W-1:0]   r5_ff;
   logic [lpc_pkg::NUM_W-1:0] num5_ff [NL];
   logic [64:0]               alo5_ff [NL];
   logic [64:0]               ahi5_ff [NL];
   logic [NL-1:0]             negp5_ff;
   logic [CW-1:0]             z5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         r5_ff <= r4_ff;
         for (int k = 0; k < NL; k++) begin
            num5_ff[k] <= num4_ff[k];
            alo5_ff[k] <= sn2 * u4_ff[k][31:0];
            ahi5_ff[k] <= sn2 * u4_ff[k][63:32];
         end
         negp5_ff <= negp4_ff;
         z5_ff    <= z4_ff;
      end
   end

   // stage 6: angle term rounding and clamp
   logic                      v6_ff;
   logic [lpc_pkg::R_W-1:0]   r6_ff;
   logic [lpc_pkg::NUM_W-1:0] num6_ff [NL];
   lpc_pkg::side_type         side6_ff;
   logic [97:0]               asum_in [NL];
   logic [97:0]               ashr_in [NL];
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         asum_in[k] = 98'(alo5_ff[k]) + (98'(ahi5_ff[k]) << 32) + ROUND;
         ashr_in[k] = asum_in[k] >> (2 * COORD_FRAC_BITS);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
      if (en) begin
         r6_ff <= r5_ff;
         for (int k = 0; k < NL; k++) begin
            num6_ff[k]     <= num5_ff[k];
            side6_ff.t2[k] <= (ashr_in[k] > 98'(lpc_pkg::MAG_CLAMP)) ? lpc_pkg::MAG_CLAMP
                                                                    : ashr_in[k][50:0];
         end
         side6_ff.negp <= negp5_ff;
         side6_ff.z    <= z5_ff;
      end
   end

   // range term dividers with side data alongside
   logic [QW-1:0]     quo [NL];
   logic              dv_ff [QW];
   lpc_pkg::side_type del_ff [QW];

   genvar g;
   for (g = 0; g < NL; g++) begin : g_lane
      lpc_div_pipe u_div (
         .clock (clock),
         .en    (en),
         .num   (num6_ff[g]),
         .den   (r6_ff),
         .quot  (quo[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QW; j++) begin
            dv_ff[j] <= 1'b0;
         end
      end else if (en) begin
         dv_ff[0] <= v6_ff;
         for (int j = 1; j < QW; j++) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end
      if (en) begin
         del_ff[0] <= side6_ff;
         for (int j = 1; j < QW; j++) begin
            del_ff[j] <= del_ff[j-1];
         end
      end
   end

   assign last_v = dv_ff[QW-1];

   // combine and saturate
   logic signed [52:0]        t1_s [NL], t2_s [NL], v_in [NL];
   logic [lpc_pkg::COV_W-1:0] cov_in [NL];
   logic [lpc_pkg::COV_W-1:0] cov_ff [NL];
   logic [CW-1:0]             z_ff;
   always_comb begin
      for (int k = 0; k < NL; k++) begin
         t1_s[k] = 53'(quo[k]);
         t2_s[k] = 53'(del_ff[QW-1].t2[k]);
         if (lpc_pkg::DIAG_LANES[k]) begin
            v_in[k] = t1_s[k] + t2_s[k];
         end else if (del_ff[QW-1].negp[k]) begin
            v_in[k] = t2_s[k] - t1_s[k];
         end else begin
            v_in[k] = t1_s[k] - t2_s[k];
         end
         priority if (v_in[k] >= 53'sd140737488355328) begin
            cov_in[k] = {1'b0, {(lpc_pkg::COV_W-1){1'b1}}};
         end else if (v_in[k] < -53'sd140737488355328) begin
            cov_in[k] = {1'b1, {(lpc_pkg::COV_W-1){1'b0}}};
         end else begin
            cov_in[k] = v_in[k][lpc_pkg::COV_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ld) begin
         out_v_ff <= last_v;
      end
      if (out_ld) begin
         cov_ff <= cov_in;
         z_ff   <= del_ff[QW-1].z;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {z_ff, cov_ff[5], cov_ff[4], cov_ff[3], cov_ff[2], cov_ff[1], cov_ff[0]};

endmodule

FILE: hdl/lpc_sin_seq.sv
// sequential sine squared unit: taylor series with a 32x32 partial product
// multiplier, constant divisors by reciprocal multiply and one correction; depends on lpc_pkg
module lpc_sin_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lpc_pkg::ANG_W-1:0]   mdeg,
   output logic                        busy,
   output logic [lpc_pkg::SN2_W-1:0]   sn2
);

   typedef enum logic [2:0] {ST_START, ST_MUL, ST_NEXT, ST_FIX, ST_ACC, ST_IDLE} state_type;
   typedef enum logic [2:0] {OP_X, OP_X2, OP_TERM, OP_RECIP, OP_SQ} op_type;

   state_type      state_ff;
   op_type         op_ff;
   logic [1:0]     cnt_ff;
   logic [3:0]     k_ff;
   logic [127:0]   acc_ff;
   logic [63:0]    ma_ff, mb_ff, x2_ff, sum_ff, dvd_ff, qt_ff;
   logic [lpc_pkg::SN2_W-1:0] sn2_ff;

   logic [31:0]    a_part, b_part;
   logic [127:0]   pp_in;
   logic [63:0]    shr60;
   logic [8:0]     div;
   logic [63:0]    fix_rem;
   logic           fix_ge;
   logic [63:0]    sum_in;
   logic [63:0]    sq_rnd;

   always_comb begin
      a_part  = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_part  = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp_in   = {64'd0, 64'(a_part) * 64'(b_part)}
                << (7'd32 * ({6'd0, cnt_ff[1]} + {6'd0, cnt_ff[0]}));
      shr60   = acc_ff[123:60];
      div     = lpc_pkg::term_divisor(k_ff);
      fix_rem = dvd_ff - 64'(qt_ff * {55'd0, div});
      fix_ge  = fix_rem >= {55'd0, div};
      sum_in  = k_ff[0] ? sum_ff - qt_ff : sum_ff + qt_ff;
      sq_rnd  = (shr60 + (64'd1 << 27)) >> 28;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_START;
         op_ff    <= OP_X;
         cnt_ff   <= '0;
         k_ff     <= 4'd1;
         sn2_ff   <= '0;
      end else if (start) begin
         state_ff <= ST_START;
      end else begin
         unique case (state_ff)
            ST_START: begin
               ma_ff    <= {48'd0, mdeg};
               mb_ff    <= lpc_pkg::RAD_PER_MDEG;
               op_ff    <= OP_X;
               acc_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               acc_ff <= acc_ff + pp_in;
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= ST_NEXT;
               end
            end
            ST_NEXT: begin
               acc_ff <= '0;
               cnt_ff <= '0;
               unique case (op_ff)
                  OP_X: begin
                     sum_ff   <= acc_ff[63:0];
                     ma_ff    <= acc_ff[63:0];
                     mb_ff    <= acc_ff[63:0];
                     op_ff    <= OP_X2;
                     state_ff <= ST_MUL;
                  end
                  OP_X2: begin
                     x2_ff    <= shr60;
                     ma_ff    <= sum_ff;
                     mb_ff    <= shr60;
                     k_ff     <= 4'd1;
                     op_ff    <= OP_TERM;
                     state_ff <= ST_MUL;
                  end
                  OP_TERM: begin
                     dvd_ff   <= shr60;
                     ma_ff    <= shr60;
                     mb_ff    <= lpc_pkg::term_recip(k_ff);
                     op_ff    <= OP_RECIP;
                     state_ff <= ST_MUL;
                  end
                  OP_RECIP: begin
                     qt_ff    <= acc_ff[127:64];
                     state_ff <= ST_FIX;
                  end
                  OP_SQ: begin
                     sn2_ff   <= sq_rnd[lpc_pkg::SN2_W-1:0];
                     state_ff <= ST_IDLE;
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_FIX: begin
               // reciprocal estimate is at most one low
               if (fix_ge) begin
                  qt_ff <= qt_ff + 64'd1;
               end
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               sum_ff   <= sum_in;
               acc_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_MUL;
               if (k_ff == 4'd10) begin
                  ma_ff <= sum_in;
                  mb_ff <= sum_in;
                  op_ff <= OP_SQ;
               end else begin
                  ma_ff <= qt_ff;
                  mb_ff <= x2_ff;
                  k_ff  <= k_ff + 4'd1;
                  op_ff <= OP_TERM;
               end
            end
            ST_IDLE: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign sn2  = sn2_ff;

endmodule

FILE: hdl/lpc_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, for the range term
// depends on lpc_pkg; quotient must fit lpc_pkg::QUO_W bits
module lpc_div_pipe (
   input  logic                        clock,
   input  logic                        en,
   input  logic [lpc_pkg::NUM_W-1:0]   num,
   input  logic [lpc_pkg::R_W-1:0]     den,
   output logic [lpc_pkg::QUO_W-1:0]   quot
);

   localparam int QW = lpc_pkg::QUO_W;
   localparam int RW = lpc_pkg::R_W;

   logic [RW-1:0] rem_ff [QW];
   logic [QW-1:0] nlo_ff [QW];
   logic [RW-1:0] den_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   genvar j;
   for (j = 0; j < QW; j++) begin : g_stage
      logic [RW-1:0] rem_src, den_src, rem_in;
      logic [QW-1:0] nlo_src, quo_src;
      logic [RW:0]   trial;
      logic          ge;

      if (j == 0) begin : g_first
         assign rem_src = RW'(num[lpc_pkg::NUM_W-1:QW]);
         assign nlo_src = num[QW-1:0];
         assign den_src = den;
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign nlo_src = nlo_ff[j-1];
         assign den_src = den_ff[j-1];
         assign quo_src = quo_ff[j-1];
      end

      always_comb begin
         trial  = {rem_src, nlo_src[QW-1]};
         ge     = trial >= {1'b0, den_src};
         rem_in = ge ? RW'(trial - {1'b0, den_src}) : trial[RW-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            nlo_ff[j] <= {nlo_src[QW-2:0], 1'b0};
            den_ff[j] <= den_src;
            quo_ff[j] <= {quo_src[QW-2:0], ge};
         end
      end
   end

   assign quot = quo_ff[QW-1];

endmodule
